// ===== src/bclce_pkg.sv =====
// Package for the bucket cache with longest-chain eviction.
// Holds default sizes, error codes and register indexes; no dependencies.
package bclce_pkg;
  localparam int unsigned ENTRIES_DEF = 256;
  localparam int unsigned BUCKETS_DEF = 64;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_STATE  = 2'd2;
  localparam logic [1:0] ERR_BUCKET = 2'd3;

  localparam logic [0:0] OP_ADD = 1'b0;
  localparam logic [0:0] OP_DEL = 1'b1;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_BUCKETS   = 1'b1;
endpackage

// ===== src/bclce_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
module bclce_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/bucket_cache_longest_chain_evict_core.sv =====
// Bucket cache with longest-chain eviction, top level.
// Depends on bclce_pkg and bclce_ram.
//
// The block keeps up to ENTRIES handles in BUCKETS doubly linked chains
// (head newest, tail oldest). One word is taken at a time; s_axis_tready is
// low while it is worked on. An add that evicts also makes one pass over the
// chain lengths, one bucket per cycle through a single compare unit, covering
// min(buckets_in_use, BUCKETS) buckets, and then unlinks the victim.
// All link tables live in single-port-read memories; entry presence has one
// flip-flop per entry and the chain tables have one valid bit per bucket,
// cleared at reset, so no clearing pass is needed. A finished result sits in
// an output register until m_axis_tready takes it, and the next word is
// accepted only then.
module bucket_cache_longest_chain_evict_core #(
  parameter int unsigned ENTRIES = bclce_pkg::ENTRIES_DEF,
  parameter int unsigned BUCKETS = bclce_pkg::BUCKETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // entry_id[7:0], bucket[13:8], zero fill
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // evicted_id[7:0], element_count[16:8],
                                     // error_code[18:17], zero fill
  output logic        m_axis_tuser,  // evicted_valid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW = $clog2(BUCKETS + 1);
  localparam int unsigned CW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHK   = 15'b000000000000010,
    S_HRD   = 15'b000000000000100,
    S_LINK  = 15'b000000000001000,
    S_LPRV  = 15'b000000000010000,
    S_SCAN  = 15'b000000000100000,
    S_SWAIT = 15'b000000001000000,
    S_TRD   = 15'b000000010000000,
    S_URD   = 15'b000000100000000,
    S_UWAIT = 15'b000001000000000,
    S_UPRV  = 15'b000010000000000,
    S_UNXT  = 15'b000100000000000,
    S_UCHN  = 15'b001000000000000,
    S_DONE  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [8:0] thr_q;
  logic [6:0] nbuck_q;
  logic [SW-1:0] limit;
  assign limit = (nbuck_q < 7'(BUCKETS)) ? SW'(nbuck_q) : SW'(BUCKETS);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      nbuck_q <= 7'd64;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bclce_pkg::REG_THRESHOLD: thr_q <= cfg_data_i;
        bclce_pkg::REG_BUCKETS:   nbuck_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Entry presence and per-bucket valid bits.
  logic [ENTRIES-1:0] present_q;
  logic [BUCKETS-1:0] bvalid_q;

  // Memories: next, prev, entry bucket, and chain head/tail/length.
  logic          nx_we, pv_we, eb_we, ch_we;
  logic [EW-1:0] nx_wa, pv_wa, eb_wa, nx_ra, pv_ra, eb_ra;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [BW-1:0] eb_wd, eb_rd, ch_wa, ch_ra;
  logic [3*LW-1:0] ch_wd, ch_rd;

  bclce_ram #(.DEPTH(ENTRIES), .WIDTH(LW)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(nx_ra), .rdata_o(nx_rd));
  bclce_ram #(.DEPTH(ENTRIES), .WIDTH(LW)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .raddr_i(pv_ra), .rdata_o(pv_rd));
  bclce_ram #(.DEPTH(ENTRIES), .WIDTH(BW)) u_ebkt (
    .clk_i, .we_i(eb_we), .waddr_i(eb_wa), .wdata_i(eb_wd),
    .raddr_i(eb_ra), .rdata_o(eb_rd));
  bclce_ram #(.DEPTH(1 << BW), .WIDTH(3*LW)) u_chain (
    .clk_i, .we_i(ch_we), .waddr_i(ch_wa), .wdata_i(ch_wd),
    .raddr_i(ch_ra), .rdata_o(ch_rd));

  // Chain word read through the bucket valid bit: {len, tail, head}.
  logic          ch_rv_q;
  logic [LW-1:0] c_head, c_tail, c_len;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ch_rv_q <= 1'b0;
    else ch_rv_q <= bvalid_q[ch_ra];
  end
  assign c_head = ch_rv_q ? ch_rd[LW-1:0] : NIL;
  assign c_tail = ch_rv_q ? ch_rd[2*LW-1:LW] : NIL;
  assign c_len  = ch_rv_q ? ch_rd[3*LW-1:2*LW] : '0;

  // Working registers.
  logic          op_q;
  logic [7:0]    id_in_q;
  logic [5:0]    bk_in_q;
  logic [EW-1:0] id_q;
  logic [BW-1:0] bk_q, best_q;
  logic [LW-1:0] best_len_q, cnt_q, uh_q, ut_q, ul_q, up_q, un_q, victim_q;
  logic [SW-1:0] scan_q;
  logic          evict_q, vic_q, scan_rd_q;
  logic          ev_valid_q;
  logic [7:0]    ev_id_q;
  logic [1:0]    err_q;
  logic          pres_q;

  logic id_ok, add_bad_bucket, evict_now;
  assign id_ok = ({1'b0, id_in_q} < 9'(ENTRIES)) || (ENTRIES > 256);
  assign add_bad_bucket = ({1'b0, bk_in_q} >= 7'(limit));
  // Eviction fires only when the count before the add equals the threshold.
  assign evict_now = (thr_q != 9'd0) && (CW'(thr_q) == CW'(cnt_q));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = ev_valid_q;
  assign m_axis_tdata  = {5'b0, err_q, cnt_q[8:0], ev_id_q};

  always_comb begin
    state_d = state_q;
    nx_we = 1'b0; pv_we = 1'b0; eb_we = 1'b0; ch_we = 1'b0;
    nx_wa = id_q; pv_wa = id_q; eb_wa = id_q; ch_wa = bk_q;
    nx_wd = NIL;  pv_wd = NIL;  eb_wd = bk_q; ch_wd = '0;
    nx_ra = id_q; pv_ra = id_q; eb_ra = id_q; ch_ra = bk_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_CHK;
      S_CHK: begin
        if (op_q == bclce_pkg::OP_ADD) begin
          if (add_bad_bucket || !id_ok || pres_q) state_d = S_DONE;
          else if (!evict_now && cnt_q >= LW'(ENTRIES)) state_d = S_DONE;
          else state_d = S_HRD;
        end else begin
          if (!id_ok || !pres_q) state_d = S_DONE;
          else state_d = S_URD;
        end
      end
      S_HRD: state_d = S_LINK;
      S_LINK: begin
        // Link at head: new entry's links and the chain word. The new
        // entry's prev is null; the old head's prev follows next cycle.
        nx_we = 1'b1; nx_wd = c_head;
        pv_we = 1'b1;
        eb_we = 1'b1;
        ch_we = 1'b1;
        ch_wd = {c_len + 1'b1, (c_head == NIL) ? LW'(id_q) : c_tail, LW'(id_q)};
        state_d = S_LPRV;
      end
      S_LPRV: begin
        if (uh_q != NIL) begin
          pv_we = 1'b1; pv_wa = uh_q[EW-1:0]; pv_wd = LW'(id_q);
        end
        state_d = evict_q ? S_SCAN : S_DONE;
      end
      default: ;
    endcase
    unique case (state_q)
      S_SCAN: begin
        ch_ra = scan_q[BW-1:0];
        if (scan_q == limit) state_d = S_SWAIT;
      end
      S_SWAIT: begin
        ch_ra = best_q;
        state_d = S_TRD;
      end
      S_TRD: begin
        if (c_tail == NIL) state_d = S_DONE;
        else state_d = S_URD;
      end
      S_URD: begin
        nx_ra = id_q; pv_ra = id_q; eb_ra = id_q;
        state_d = S_UWAIT;
      end
      S_UWAIT: begin
        ch_ra = eb_rd;
        state_d = S_UPRV;
      end
      S_UPRV: begin
        if (up_q != NIL) begin
          nx_we = 1'b1; nx_wa = up_q[EW-1:0]; nx_wd = un_q;
        end
        state_d = S_UNXT;
      end
      S_UNXT: begin
        if (un_q != NIL) begin
          pv_we = 1'b1; pv_wa = un_q[EW-1:0]; pv_wd = up_q;
        end
        state_d = S_UCHN;
      end
      S_UCHN: begin
        ch_we = 1'b1; ch_wa = bk_q;
        ch_wd = {ul_q - 1'b1, (un_q == NIL) ? up_q : ut_q,
                 (up_q == NIL) ? un_q : uh_q};
        state_d = S_DONE;
      end
      S_DONE: state_d = S_OUT;
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      present_q <= '0;
      bvalid_q <= '0;
      cnt_q <= '0;
      scan_rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ch_we) bvalid_q[ch_wa] <= 1'b1;
      scan_rd_q <= (state_q == S_SCAN) && (scan_q != limit);
      unique case (state_q)
        S_LINK: begin
          present_q[id_q] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
        S_UCHN: begin
          present_q[id_q] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q <= s_axis_tuser;
        id_in_q <= s_axis_tdata[7:0];
        bk_in_q <= s_axis_tdata[13:8];
        id_q <= EW'(s_axis_tdata[7:0]);
        bk_q <= BW'(s_axis_tdata[13:8]);
        pres_q <= present_q[EW'(s_axis_tdata[7:0])];
        ev_valid_q <= 1'b0;
        ev_id_q <= '0;
        vic_q <= 1'b0;
        err_q <= bclce_pkg::ERR_OK;
      end
      S_CHK: begin
        evict_q <= evict_now;
        if (op_q == bclce_pkg::OP_ADD) begin
          if (add_bad_bucket) err_q <= bclce_pkg::ERR_BUCKET;
          else if (!id_ok || pres_q) err_q <= bclce_pkg::ERR_STATE;
          else if (!evict_now && cnt_q >= LW'(ENTRIES)) err_q <= bclce_pkg::ERR_FULL;
        end else if (!id_ok || !pres_q) begin
          err_q <= bclce_pkg::ERR_STATE;
        end
      end
      S_LINK: begin
        uh_q <= c_head;
        best_q <= bk_q;
        best_len_q <= c_len + 1'b1;
        scan_q <= '0;
      end
      S_SCAN: begin
        if (scan_q != limit) scan_q <= scan_q + 1'b1;
        // One compare a cycle against the length read a cycle ago.
        if (scan_rd_q && c_len > best_len_q) begin
          best_len_q <= c_len;
          best_q <= BW'(scan_q - 1'b1);
        end
      end
      S_SWAIT: begin
        if (scan_rd_q && c_len > best_len_q) begin
          best_len_q <= c_len;
          best_q <= BW'(scan_q - 1'b1);
        end
      end
      S_TRD: begin
        victim_q <= c_tail;
        id_q <= c_tail[EW-1:0];
        vic_q <= (c_tail != NIL);
      end
      S_UWAIT: begin
        up_q <= pv_rd;
        un_q <= nx_rd;
        bk_q <= eb_rd;
      end
      S_UPRV: begin
        uh_q <= c_head;
        ut_q <= c_tail;
        ul_q <= c_len;
      end
      S_DONE: begin
        if (vic_q) begin
          ev_valid_q <= 1'b1;
          ev_id_q <= victim_q[7:0];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // A result never reports an eviction together with an error.
  a_ev_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tdata[18:17] != bclce_pkg::ERR_OK))
    else $error("eviction reported with error");
  // No new word is taken while a result is pending.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");
  // The held count stays within the store size.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(ENTRIES))
    else $error("held count out of range");
`endif
endmodule
